// ===== rtl/core/bic_pkg.sv =====
// ----------------------------------------------------------------------------
// bic_pkg: shared definitions for the banked interrupt controller
// Register offsets, shortcut line map, result and mask structs, and the
// priority encoder helpers used by the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bic_pkg;

  // Register byte offsets.
  localparam logic [5:0] OFS_BASIC_PEND = 6'h00;
  localparam logic [5:0] OFS_PEND_ONE   = 6'h04;
  localparam logic [5:0] OFS_PEND_TWO   = 6'h08;
  localparam logic [5:0] OFS_EN_ONE     = 6'h10;
  localparam logic [5:0] OFS_EN_TWO     = 6'h14;
  localparam logic [5:0] OFS_EN_BASIC   = 6'h18;
  localparam logic [5:0] OFS_DIS_ONE    = 6'h1c;
  localparam logic [5:0] OFS_DIS_TWO    = 6'h20;
  localparam logic [5:0] OFS_DIS_BASIC  = 6'h24;

  // Access kind carried on the input tuser bit.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Shortcut lines inside each bank; excluded from the bank summary bits.
  localparam logic [31:0] SHORTCUT_MASK_ONE = 32'h000c_0680;
  localparam logic [31:0] SHORTCUT_MASK_TWO = 32'h43e0_0000;
  localparam int unsigned NUM_SHORTCUTS     = 11;

  // Source numbering bases.
  localparam logic [6:0] BASE_BANK_TWO = 7'd32;
  localparam logic [6:0] BASE_BASIC    = 7'd64;

  // Item field widths.
  localparam int unsigned OFS_W    = 6;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BANK_W   = 32;
  localparam int unsigned BASIC_W  = 8;
  localparam int unsigned IRQ_W    = 7;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic [BANK_W-1:0]  bank_one;
    logic [BANK_W-1:0]  bank_two;
    logic [BASIC_W-1:0] basic;
  } masks_t;

  typedef struct packed {
    logic [IRQ_W-1:0]  irq_number;
    logic              irq_valid;
    logic [DATA_W-1:0] read_data;
  } result_t;

  // Source number of each shortcut bit position 10..20 of basic pending.
  function automatic logic [IRQ_W-1:0] shortcut_line(input logic [3:0] idx);
    logic [IRQ_W-1:0] line;
    case (idx)
      4'd0:    line = 7'd7;
      4'd1:    line = 7'd9;
      4'd2:    line = 7'd10;
      4'd3:    line = 7'd18;
      4'd4:    line = 7'd19;
      4'd5:    line = 7'd53;
      4'd6:    line = 7'd54;
      4'd7:    line = 7'd55;
      4'd8:    line = 7'd56;
      4'd9:    line = 7'd57;
      4'd10:   line = 7'd62;
      default: line = 7'd0;
    endcase
    return line;
  endfunction

  // Index of the highest set bit of a 32-bit word, zero when none is set.
  function automatic logic [4:0] top_bit32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // Index of the highest set bit of an 11-bit word, zero when none is set.
  function automatic logic [3:0] top_bit11(input logic [10:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 11; i++) begin
      if (v[i]) n = 4'(i);
    end
    return n;
  endfunction

  // Index of the highest set bit of an 8-bit word, zero when none is set.
  function automatic logic [2:0] top_bit8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 3'(i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bic_datapath.sv =====
// ----------------------------------------------------------------------------
// bic_datapath: single-pass access and dispatch logic
// Applies a register write to the enable masks, forms the pending words,
// selects read data and picks the source to service, all in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bic_datapath (
  input  wire logic                        mode,
  input  wire logic [bic_pkg::OFS_W-1:0]   reg_offset,
  input  wire logic [bic_pkg::DATA_W-1:0]  write_data,
  input  wire logic [bic_pkg::BANK_W-1:0]  lines_bank_one,
  input  wire logic [bic_pkg::BANK_W-1:0]  lines_bank_two,
  input  wire logic [bic_pkg::BASIC_W-1:0] lines_basic,
  input  wire bic_pkg::masks_t             masks_cur,
  output bic_pkg::masks_t                  masks_nxt,
  output bic_pkg::result_t                 result
);
  import bic_pkg::*;

  logic [BANK_W-1:0]  pend_one;
  logic [BANK_W-1:0]  pend_two;
  logic [BASIC_W-1:0] pend_basic;
  logic [10:0]        shortcut_pend;
  logic               sum_one;
  logic               sum_two;
  logic [DATA_W-1:0]  basic_word;
  logic [DATA_W-1:0]  rd_word;
  logic               irq_found;
  logic [IRQ_W-1:0]   irq_num;

  // Mask update: enable registers set bits, disable registers clear them.
  always_comb begin
    masks_nxt = masks_cur;
    if (mode == MODE_WRITE) begin
      unique case (reg_offset)
        OFS_EN_ONE:    masks_nxt.bank_one = masks_cur.bank_one | write_data;
        OFS_EN_TWO:    masks_nxt.bank_two = masks_cur.bank_two | write_data;
        OFS_EN_BASIC:  masks_nxt.basic = masks_cur.basic | write_data[BASIC_W-1:0];
        OFS_DIS_ONE:   masks_nxt.bank_one = masks_cur.bank_one & ~write_data;
        OFS_DIS_TWO:   masks_nxt.bank_two = masks_cur.bank_two & ~write_data;
        OFS_DIS_BASIC: masks_nxt.basic = masks_cur.basic & ~write_data[BASIC_W-1:0];
        default:       masks_nxt = masks_cur;
      endcase
    end
  end

  // Pending words use the masks as they stand after this item's write.
  assign pend_one   = lines_bank_one & masks_nxt.bank_one;
  assign pend_two   = lines_bank_two & masks_nxt.bank_two;
  assign pend_basic = lines_basic & masks_nxt.basic;

  assign sum_one = |(pend_one & ~SHORTCUT_MASK_ONE);
  assign sum_two = |(pend_two & ~SHORTCUT_MASK_TWO);

  assign shortcut_pend = {pend_two[30], pend_two[25], pend_two[24], pend_two[23],
                          pend_two[22], pend_two[21], pend_one[19], pend_one[18],
                          pend_one[10], pend_one[9],  pend_one[7]};

  assign basic_word = {11'd0, shortcut_pend, sum_two, sum_one, pend_basic};

  // Read data selection; writes and unmapped offsets return zero.
  always_comb begin
    rd_word = '0;
    if (mode == MODE_READ) begin
      unique case (reg_offset)
        OFS_BASIC_PEND:          rd_word = basic_word;
        OFS_PEND_ONE:            rd_word = pend_one;
        OFS_PEND_TWO:            rd_word = pend_two;
        OFS_EN_ONE, OFS_DIS_ONE: rd_word = masks_nxt.bank_one;
        OFS_EN_TWO, OFS_DIS_TWO: rd_word = masks_nxt.bank_two;
        OFS_EN_BASIC, OFS_DIS_BASIC:
          rd_word = {{(DATA_W-BASIC_W){1'b0}}, masks_nxt.basic};
        default:                 rd_word = '0;
      endcase
    end
  end

  // Dispatch in handler order: bank one, bank two, shortcuts, basic lines.
  always_comb begin
    irq_found = 1'b1;
    irq_num   = '0;
    if (sum_one) begin
      irq_num = {2'b00, top_bit32(pend_one)};
    end else if (sum_two) begin
      irq_num = BASE_BANK_TWO | {2'b00, top_bit32(pend_two)};
    end else if (|shortcut_pend) begin
      irq_num = shortcut_line(top_bit11(shortcut_pend));
    end else if (|pend_basic) begin
      irq_num = BASE_BASIC | {4'b0000, top_bit8(pend_basic)};
    end else begin
      irq_found = 1'b0;
    end
  end

  assign result = {irq_num, irq_found, rd_word};

endmodule

`default_nettype wire

// ===== rtl/core/banked_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// banked_interrupt_controller: 72-line banked interrupt controller
// Register access over a stream channel, with the chosen source reported
// alongside every access.
// ----------------------------------------------------------------------------
// One item (a register access plus the current source line levels) is
// accepted per clock cycle while in_tready is high. Its result is computed
// in a single combinational pass from the item and the enable masks and is
// registered in the result register, or in the skid register while that is
// occupied; a write takes effect on the masks used for that same item. A
// two-entry output buffer lets the block keep accepting while a result
// waits, so in_tready drops only when both entries hold results not taken.
`timescale 1ns / 1ps
`default_nettype none

module banked_interrupt_controller (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // tdata: reg_offset[5:0], write_data[37:6], lines_bank_one[69:38],
  //        lines_bank_two[101:70], lines_basic[109:102], zero fill [111:110]
  input  wire logic [bic_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: mode (0 write, 1 read)
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // tdata: read_data[31:0], irq_valid[32], irq_number[39:33]
  output logic [bic_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import bic_pkg::*;

  masks_t  masks_r;
  masks_t  masks_nxt;
  result_t result;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_accept;
  logic    out_take;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  bic_datapath u_datapath (
    .mode           (in_tuser),
    .reg_offset     (in_tdata[5:0]),
    .write_data     (in_tdata[37:6]),
    .lines_bank_one (in_tdata[69:38]),
    .lines_bank_two (in_tdata[101:70]),
    .lines_basic    (in_tdata[109:102]),
    .masks_cur      (masks_r),
    .masks_nxt      (masks_nxt),
    .result         (result)
  );

  // Enable masks advance with each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= '0;
    end else if (in_accept) begin
      masks_r <= masks_nxt;
    end
  end

  // Output buffer control: result register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_take) begin
        out_valid_r  <= skid_valid_r || in_accept;
        skid_valid_r <= skid_valid_r && in_accept;
      end else if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (in_accept) skid_r <= result;
      end else if (in_accept) begin
        out_r <= result;
      end
    end else if (in_accept) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // The skid register only ever holds an item queued behind the result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without a result entry");

  // An item accepted while the result stalls must land in the skid register.
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && in_accept) |=> skid_valid_r)
    else $error("item accepted during stall was not buffered");

  // A reported result with no pending source carries source number zero.
  a_idle_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.irq_valid) |-> (out_r.irq_number == '0))
    else $error("nonzero source number with nothing pending");

  // Masks are unchanged in cycles without an accepted item.
  a_masks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(masks_r))
    else $error("enable masks changed without an accepted item");

  // The basic mask never picks up bits from a write to a bank register.
  a_basic_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == MODE_WRITE &&
     (in_tdata[5:0] == OFS_EN_ONE || in_tdata[5:0] == OFS_EN_TWO))
    |=> (masks_r.basic == $past(masks_r.basic)))
    else $error("bank enable write disturbed the basic mask");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the banked interrupt controller
// Drives register accesses with line levels over the input stream and checks
// every result field by field against a scripted result or an in-bench model
// of the masks, the pending words and the dispatch priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bic_pkg::*;

  // Offsets that decode to no register.
  localparam logic [5:0] OFS_FIQ_CTRL  = 6'h0c;
  localparam logic [5:0] OFS_UNALIGNED = 6'h11;
  localparam logic [5:0] OFS_TOP_END   = 6'h3f;

  localparam int unsigned N_RANDOM    = 1600;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic               mode;
    logic [OFS_W-1:0]   ofs;
    logic [DATA_W-1:0]  wdata;
    logic [BANK_W-1:0]  lines_one;
    logic [BANK_W-1:0]  lines_two;
    logic [BASIC_W-1:0] lines_basic;
  } access_t;

  typedef struct packed {
    access_t acc;
    logic    fixed;
    result_t res;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Bench copy of the enable masks, and the results still owed by the block.
  masks_t      enables = '0;
  result_t     due_results[$];
  script_row_t script[$];

  int unsigned n_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          tail_phase = 1'b0;
  bit          long_hold_done = 1'b0;
  result_t     want_result;
  result_t     got_result;

  banked_interrupt_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bit index of the highest one in a word, zero for an empty word.
  function automatic logic [IRQ_W-1:0] highest_one(input logic [31:0] v);
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) return IRQ_W'(i);
    end
    return '0;
  endfunction

  // Applies one access to the mask copy and returns the result it causes.
  function automatic result_t service_access(input access_t a);
    result_t            r;
    logic [BANK_W-1:0]  pend_one;
    logic [BANK_W-1:0]  pend_two;
    logic [BASIC_W-1:0] pend_basic;
    logic [10:0]        shortcuts;
    logic [31:0]        basic_word;
    r = '0;
    if (a.mode == MODE_WRITE) begin
      case (a.ofs)
        OFS_EN_ONE:    enables.bank_one = enables.bank_one | a.wdata;
        OFS_EN_TWO:    enables.bank_two = enables.bank_two | a.wdata;
        OFS_EN_BASIC:  enables.basic    = enables.basic | a.wdata[BASIC_W-1:0];
        OFS_DIS_ONE:   enables.bank_one = enables.bank_one & ~a.wdata;
        OFS_DIS_TWO:   enables.bank_two = enables.bank_two & ~a.wdata;
        OFS_DIS_BASIC: enables.basic    = enables.basic & ~a.wdata[BASIC_W-1:0];
        default: ;
      endcase
    end

    pend_one   = a.lines_one & enables.bank_one;
    pend_two   = a.lines_two & enables.bank_two;
    pend_basic = a.lines_basic & enables.basic;
    // Shortcut copies, lowest source first: 7, 9, 10, 18, 19, 53-57, 62.
    shortcuts  = {pend_two[30], pend_two[25:21], pend_one[19:18], pend_one[10:9],
                  pend_one[7]};
    basic_word = {11'b0, shortcuts, |(pend_two & ~SHORTCUT_MASK_TWO),
                  |(pend_one & ~SHORTCUT_MASK_ONE), pend_basic};

    if (a.mode == MODE_READ) begin
      case (a.ofs)
        OFS_BASIC_PEND:            r.read_data = basic_word;
        OFS_PEND_ONE:              r.read_data = pend_one;
        OFS_PEND_TWO:              r.read_data = pend_two;
        OFS_EN_ONE, OFS_DIS_ONE:   r.read_data = enables.bank_one;
        OFS_EN_TWO, OFS_DIS_TWO:   r.read_data = enables.bank_two;
        OFS_EN_BASIC, OFS_DIS_BASIC: r.read_data = {24'b0, enables.basic};
        default:                   r.read_data = '0;
      endcase
    end

    // Without a summary bit every pending bank line is a shortcut line, and
    // the shortcut order follows the source number, so the highest pending
    // shortcut is the highest pending line of bank two, else of bank one.
    if (basic_word[8]) begin
      r.irq_valid  = 1'b1;
      r.irq_number = highest_one(pend_one);
    end else if (basic_word[9]) begin
      r.irq_valid  = 1'b1;
      r.irq_number = BASE_BANK_TWO + highest_one(pend_two);
    end else if (|shortcuts) begin
      r.irq_valid  = 1'b1;
      r.irq_number = (|pend_two) ? BASE_BANK_TWO + highest_one(pend_two)
                                 : highest_one(pend_one);
    end else if (|pend_basic) begin
      r.irq_valid  = 1'b1;
      r.irq_number = BASE_BASIC + highest_one({24'b0, pend_basic});
    end
    return r;
  endfunction

  // One mismatch line, and a count; printing stops after a few dozen.
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
               cycle_count, what, want, got);
    end
  endtask

  // A word shaped to reach the different priority levels.
  function automatic logic [31:0] pick_word(input logic [31:0] shortcut_mask);
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2, 3:    w = 32'(1) << $urandom_range(0, 31);
      4, 5, 6: w = $urandom & shortcut_mask;
      7:       w = $urandom & $urandom & $urandom;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic script_row_t row(input logic mode, input logic [5:0] ofs,
                                      input logic [31:0] wdata,
                                      input logic [31:0] l1, input logic [31:0] l2,
                                      input logic [7:0] lb, input logic fixed,
                                      input logic [31:0] rd, input logic v,
                                      input logic [6:0] num);
    script_row_t s;
    s.acc   = '{mode, ofs, wdata, l1, l2, lb};
    s.fixed = fixed;
    s.res   = '{num, v, rd};
    return s;
  endfunction

  // Offers one item, waits for it to be taken and records its result.
  task automatic drive_access(input access_t a, input logic fixed,
                              input result_t fixed_res);
    result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= a.mode;
    in_tdata  <= {2'b00, a.lines_basic, a.lines_two, a.lines_one, a.wdata, a.ofs};
    do @(posedge clk); while (!in_tready);
    predicted = service_access(a);
    due_results.push_back(fixed ? fixed_res : predicted);
    n_accepted++;
  endtask

  // Random pause of the sender before an item, skipped near the end.
  task automatic sender_gap;
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result = result_t'(out_tdata);
      if (due_results.size() == 0) begin
        flag_mismatch("result with no access outstanding", '0, got_result.read_data);
      end else begin
        want_result = due_results.pop_front();
        if (got_result.read_data != want_result.read_data)
          flag_mismatch("read_data", want_result.read_data, got_result.read_data);
        if (got_result.irq_valid != want_result.irq_valid)
          flag_mismatch("irq_valid", 32'(want_result.irq_valid),
                        32'(got_result.irq_valid));
        if (got_result.irq_number != want_result.irq_number)
          flag_mismatch("irq_number", 32'(want_result.irq_number),
                        32'(got_result.irq_number));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, and one long hold-off that backs up the
  // output buffer until the block stops taking items.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (!long_hold_done && n_accepted >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 16)) @(posedge clk);
        if (!tail_phase) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    access_t a;
    logic    pick_two;

    // Directed accesses: reset state, extremes, ignored writes, unmapped
    // offsets, each priority level and the basic-bank byte limit.
    script.push_back(row(MODE_READ,  OFS_BASIC_PEND, '0, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_EN_ONE,     '0, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_EN_TWO,     '0, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_EN_BASIC,   '0, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_PEND_ONE,   '1, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_EN_ONE,     '1, '0, '0, '0, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_EN_ONE,     '0, '0, '0, '0, 1, '1, 0, 0));
    script.push_back(row(MODE_READ,  OFS_PEND_ONE,   '0, '1, '0, '0, 1, '1, 1, 31));
    script.push_back(row(MODE_READ,  OFS_BASIC_PEND, '0, SHORTCUT_MASK_ONE, '0, '0,
                         0, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_EN_TWO,     '1, SHORTCUT_MASK_ONE, 32'h1, '0,
                         0, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_EN_BASIC,   '1, '0, '0, '1, 1, '0, 1, 71));
    script.push_back(row(MODE_READ,  OFS_DIS_BASIC,  '0, '0, '0, '0, 1, 32'hff, 0, 0));
    script.push_back(row(MODE_READ,  OFS_PEND_TWO,   '0, '0, '1, '0, 1, '1, 1, 63));
    script.push_back(row(MODE_READ,  OFS_BASIC_PEND, '0, SHORTCUT_MASK_ONE,
                         SHORTCUT_MASK_TWO, '1, 0, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_FIQ_CTRL,   '1, '1, '1, '1, 1, '0, 1, 31));
    script.push_back(row(MODE_READ,  OFS_UNALIGNED,  '0, '0, '0, '0, 1, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_TOP_END,    '1, '0, '0, '0, 1, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_DIS_ONE,    32'h8000_0001, '1, '0, '0,
                         0, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_DIS_TWO,    '1, '0, '1, '0, 1, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_DIS_BASIC,  32'hffff_ff00, '0, '0, 8'h01,
                         0, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_DIS_BASIC,  '1, '0, '0, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_DIS_ONE,    '0, '0, '0, '0, 0, '0, 0, 0));
    script.push_back(row(MODE_WRITE, OFS_DIS_ONE,    '1, '1, '1, '1, 1, '0, 0, 0));
    script.push_back(row(MODE_READ,  OFS_DIS_TWO,    '0, '1, '1, '1, 1, '0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      sender_gap();
      drive_access(script[i].acc, script[i].fixed, script[i].res);
    end

    // Random accesses, weighted toward the mapped registers.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      tail_phase = (i >= N_RANDOM - TAIL_ITEMS);
      pick_two   = 1'($urandom_range(0, 1));
      a.mode     = ($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ;
      case ($urandom_range(0, 12))
        0:       a.ofs = OFS_BASIC_PEND;
        1:       a.ofs = OFS_PEND_ONE;
        2:       a.ofs = OFS_PEND_TWO;
        3:       a.ofs = OFS_EN_ONE;
        4:       a.ofs = OFS_EN_TWO;
        5:       a.ofs = OFS_EN_BASIC;
        6:       a.ofs = OFS_DIS_ONE;
        7:       a.ofs = OFS_DIS_TWO;
        8:       a.ofs = OFS_DIS_BASIC;
        default: a.ofs = OFS_W'($urandom_range(0, 63));
      endcase
      a.wdata       = pick_word(pick_two ? SHORTCUT_MASK_TWO : SHORTCUT_MASK_ONE);
      a.lines_one   = pick_word(SHORTCUT_MASK_ONE);
      a.lines_two   = pick_word(SHORTCUT_MASK_TWO);
      a.lines_basic = ($urandom_range(0, 3) == 0) ? '0 : BASIC_W'($urandom);
      sender_gap();
      drive_access(a, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then a short settle.
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
